// File: design/cwt_pkg.sv
// Shared types, codes and sizes for the card identifier allow-list table.
package cwt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int UID_W           = 40;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [UID_W-1:0] card_uid;
  } cwt_in_t;

  typedef struct packed {
    logic       found;
    logic [3:0] match_slot;
    logic [1:0] status;
    logic [4:0] entry_count;
    logic       unsaved_change;
  } cwt_out_t;

endpackage

// File: design/cwt_mem.sv
// Identifier store: one write port, one read port with registered read data.
module cwt_mem #(
  parameter int DEPTH = cwt_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [cwt_pkg::UID_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic [cwt_pkg::UID_W-1:0] rd_data
);
  import cwt_pkg::*;

  logic [UID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/card_uid_whitelist_table_unit.sv
// Top level of the card identifier allow-list table: sequencer over the identifier store.
// Sequence: a lookup, an add or a missed delete reads and compares the filled entries in order,
// up to and including the first match (all of them when none matches), then applies the operation;
// a hit delete also shifts each later entry down one slot and then marks the vacated slot.
// Throughput: one request at a time; busy stays high until the result strobe, which the
// receiver cannot stall. The search pace is set by the single read port (read, compare).
// Reset (rst_n low, synchronous): fill count and changed mark clear, table contents stay.
module card_uid_whitelist_table_unit #(
  parameter int TABLE_DEPTH = cwt_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cwt_pkg::cwt_in_t  in_req,
  output logic              out_valid,
  output cwt_pkg::cwt_out_t out_res
);
  import cwt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;  // issue search read
  localparam logic [2:0] S_SCMP = 3'd2;  // compare read data
  localparam logic [2:0] S_EXEC = 3'd3;  // apply the operation
  localparam logic [2:0] S_DRD  = 3'd4;  // issue shift read
  localparam logic [2:0] S_DWR  = 3'd5;  // write shifted entry
  localparam logic [2:0] S_FILL = 3'd6;  // mark vacated slot

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             changed_r, changed_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             hit_r, hit_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [UID_W-1:0] uid_r, uid_nxt;
  logic             out_valid_r, out_valid_nxt;
  cwt_out_t         out_res_r, out_res_nxt;
  logic [1:0]       status_c;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [UID_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [UID_W-1:0] rd_data;

  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W:0]   idx_p1_w, idx_p2_w, fill_w, slot_p1_w;
  logic [CNT_W-1:0] fill_m1;
  logic [IDX_W+3:0] slot_ext;
  logic [CNT_W+4:0] cnt_ext;

  assign idx_p1    = idx_r + 1'b1;
  assign idx_p1_w  = {1'b0, idx_r} + 1'b1;
  assign idx_p2_w  = {1'b0, idx_r} + 2'd2;
  assign fill_w    = {1'b0, fill_r};
  assign slot_p1_w = (CNT_W + 1)'(slot_r) + 1'b1;
  assign fill_m1   = fill_r - 1'b1;
  assign slot_ext  = {4'b0000, slot_r};
  assign cnt_ext   = {5'b00000, fill_nxt};

  cwt_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    changed_nxt   = changed_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    hit_nxt       = hit_r;
    op_nxt        = op_r;
    uid_nxt       = uid_r;
    out_valid_nxt = 1'b0;
    status_c      = ST_DONE;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_req.operation;
          uid_nxt  = in_req.card_uid;
          idx_nxt  = '0;
          slot_nxt = '0;
          hit_nxt  = 1'b0;
          // Skip the walk on an empty table.
          state_nxt = (fill_r == '0) ? S_EXEC : S_SRD;
        end
      end
      S_SRD: begin
        rd_en     = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rd_data == uid_r) begin
          // Stop at the first match.
          hit_nxt   = 1'b1;
          slot_nxt  = idx_r[IDX_W-1:0];
          state_nxt = S_EXEC;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = (idx_p1_w >= fill_w) ? S_EXEC : S_SRD;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            if (fill_r >= CNT_W'(TABLE_DEPTH)) begin
              status_c = ST_FULL;
            end else begin
              // Append at the end, no duplicate check.
              wr_en       = 1'b1;
              wr_addr     = fill_r[IDX_W-1:0];
              wr_data     = uid_r;
              fill_nxt    = fill_r + 1'b1;
              changed_nxt = 1'b1;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          OP_DELETE: begin
            if (!hit_r) begin
              status_c      = ST_MISSING;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              // Shift later entries down starting at the match.
              idx_nxt   = CNT_W'(slot_r);
              state_nxt = (slot_p1_w < fill_w) ? S_DRD : S_FILL;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_DRD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_p1[IDX_W-1:0];
        state_nxt = S_DWR;
      end
      S_DWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[IDX_W-1:0];
        wr_data   = rd_data;
        idx_nxt   = idx_p1;
        state_nxt = (idx_p2_w < fill_w) ? S_DRD : S_FILL;
      end
      S_FILL: begin
        // Old last filled slot reads all ones from now on.
        wr_en         = 1'b1;
        wr_addr       = fill_m1[IDX_W-1:0];
        wr_data       = '1;
        fill_nxt      = fill_m1;
        changed_nxt   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_res_nxt.found          = hit_r;
    out_res_nxt.match_slot     = slot_ext[3:0];
    out_res_nxt.status         = status_c;
    out_res_nxt.entry_count    = cnt_ext[4:0];
    out_res_nxt.unsaved_change = changed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload: no reset needed.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
    hit_r  <= hit_nxt;
    op_r   <= op_nxt;
    uid_r  <= uid_nxt;
    if (out_valid_nxt) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
